/* hdl/ir_pulse_width_frame_sender_defines.svh */
`ifndef IR_PULSE_WIDTH_FRAME_SENDER_DEFINES_SVH
`define IR_PULSE_WIDTH_FRAME_SENDER_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define IRPW_ASSERT_NOW(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("ir sender check failed");

// Next-cycle implication, checked outside reset
`define IRPW_ASSERT_NEXT(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("ir sender check failed");

`endif

/* hdl/ir_pwfs_pkg.sv */
`default_nettype none

package ir_pwfs_pkg;

  localparam int unsigned CodeW        = 4;
  localparam int unsigned TickW        = 8;
  localparam int unsigned CfgIdxW      = 2;
  localparam int unsigned CodeBitsDef  = 4;
  localparam int unsigned QueueDepth   = 2;

  localparam logic [TickW-1:0] HeaderTicksRst = 8'd32;
  localparam logic [TickW-1:0] ZeroTicksRst   = 8'd16;
  localparam logic [TickW-1:0] OneTicksRst    = 8'd64;
  localparam logic [TickW-1:0] SpaceTicksRst  = 8'd38;

  typedef enum logic [0:0] {
    CMD_TICK = 1'b0,
    CMD_SEND = 1'b1
  } cmd_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_HEADER = 2'd0,
    REG_ZERO   = 2'd1,
    REG_ONE    = 2'd2,
    REG_SPACE  = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic             cmd;
    logic [CodeW-1:0] code;
  } in_item_t;

  typedef struct packed {
    logic ir_level;
    logic busy_res;
    logic frame_done;
    logic rejected;
  } out_item_t;

  // queue entry: classified item
  typedef struct packed {
    cmd_e             cmd;
    logic [CodeW-1:0] code;
  } entry_t;

endpackage

`default_nettype wire

/* hdl/ir_pwfs_front.sv */
`default_nettype none

module ir_pwfs_front (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire ir_pwfs_pkg::in_item_t in_data_i,
  output logic                     push_o,
  input  wire logic                push_ready_i,
  output ir_pwfs_pkg::entry_t      push_data_o
);

  logic                 valid_q, valid_d;
  ir_pwfs_pkg::entry_t  entry_q, entry_d;
  logic                 take;

  assign in_ready_o = !valid_q || push_ready_i;
  assign take       = in_valid_i && in_ready_o;
  assign push_o     = valid_q;
  assign push_data_o = entry_q;

  always_comb begin
    valid_d = valid_q;
    entry_d = entry_q;
    if (take) begin
      valid_d = 1'b1;
      entry_d.cmd  = in_data_i.cmd ? ir_pwfs_pkg::CMD_SEND : ir_pwfs_pkg::CMD_TICK;
      entry_d.code = in_data_i.code;
    end else if (push_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

endmodule

`default_nettype wire

/* hdl/ir_pwfs_queue.sv */
`default_nettype none

module ir_pwfs_queue (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 push_i,
  output logic                      push_ready_o,
  input  wire ir_pwfs_pkg::entry_t  push_data_i,
  output logic                      pop_valid_o,
  input  wire logic                 pop_i,
  output ir_pwfs_pkg::entry_t       pop_data_o
);

  localparam int unsigned Depth = ir_pwfs_pkg::QueueDepth;
  localparam int unsigned PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW  = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  ir_pwfs_pkg::entry_t mem_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign push_ready_o = (cnt_q != CntFull);
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_data_o   = mem_q[rd_q];
  assign do_push      = push_i && push_ready_o;
  assign do_pop       = pop_i && pop_valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == PtrLast) ? '0 : wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= (rd_q == PtrLast) ? '0 : rd_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

/* hdl/ir_pwfs_back.sv */
`default_nettype none

`include "ir_pulse_width_frame_sender_defines.svh"

module ir_pwfs_back #(
  parameter int unsigned CODE_BITS = ir_pwfs_pkg::CodeBitsDef
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_we_i,
  input  wire logic [ir_pwfs_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  wire logic [ir_pwfs_pkg::TickW-1:0]       cfg_wdata_i,
  input  wire logic                                pop_valid_i,
  output logic                                     pop_o,
  input  wire ir_pwfs_pkg::entry_t                 pop_data_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_ready_i,
  output ir_pwfs_pkg::out_item_t                   out_data_o
);

  localparam int unsigned TickW = ir_pwfs_pkg::TickW;
  localparam int unsigned CodeW = ir_pwfs_pkg::CodeW;
  localparam int unsigned ExtW  = (CODE_BITS > CodeW) ? CODE_BITS : CodeW;
  localparam int unsigned BitW  = (CODE_BITS > 1) ? $clog2(CODE_BITS) : 1;
  localparam logic [BitW-1:0] BitLast = BitW'(CODE_BITS - 1);

  typedef enum logic [2:0] {
    PH_IDLE      = 3'd0,
    PH_HDR_BURST = 3'd1,
    PH_HDR_SPACE = 3'd2,
    PH_BIT_BURST = 3'd3,
    PH_BIT_SPACE = 3'd4
  } phase_e;

  logic [TickW-1:0] hdr_len_q, zero_len_q, one_len_q, space_len_q;

  phase_e                 phase_q, phase_d;
  logic [TickW-1:0]       tick_q, tick_d;
  logic [BitW-1:0]        bit_q, bit_d;
  logic [CODE_BITS-1:0]   shift_q, shift_d;
  logic                   level_q, level_d;
  logic                   out_valid_q, out_valid_d;
  ir_pwfs_pkg::out_item_t out_q, out_d;

  logic [ExtW-1:0]  code_ext;
  logic [TickW-1:0] len;
  logic [TickW:0]   tick_nxt;
  logic             ends;
  logic             done, rej;

  assign pop_o       = pop_valid_i && (!out_valid_q || out_ready_i);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign code_ext    = ExtW'(pop_data_i.code);
  assign tick_nxt    = {1'b0, tick_q} + 1'b1;
  assign ends        = (tick_nxt >= {1'b0, len});

  always_comb begin
    unique case (phase_q)
      PH_HDR_BURST: len = hdr_len_q;
      PH_BIT_BURST: len = shift_q[CODE_BITS-1] ? one_len_q : zero_len_q;
      default:      len = space_len_q;
    endcase
  end

  always_comb begin
    phase_d = phase_q;
    tick_d  = tick_q;
    bit_d   = bit_q;
    shift_d = shift_q;
    level_d = level_q;
    done    = 1'b0;
    rej     = 1'b0;
    if (pop_o) begin
      if (pop_data_i.cmd == ir_pwfs_pkg::CMD_SEND) begin
        if (phase_q != PH_IDLE) begin
          rej = 1'b1;
        end else begin
          phase_d = PH_HDR_BURST;
          tick_d  = '0;
          bit_d   = '0;
          shift_d = code_ext[CODE_BITS-1:0];
        end
      end else begin
        tick_d = ends ? '0 : tick_nxt[TickW-1:0];
        unique case (phase_q)
          PH_IDLE: begin
            tick_d = tick_q;
          end
          PH_HDR_BURST: begin
            level_d = !level_q;
            if (ends) phase_d = PH_HDR_SPACE;
          end
          PH_HDR_SPACE: begin
            level_d = 1'b0;
            if (ends) begin
              phase_d = PH_BIT_BURST;
              bit_d   = '0;
            end
          end
          PH_BIT_BURST: begin
            level_d = !level_q;
            if (ends) phase_d = PH_BIT_SPACE;
          end
          PH_BIT_SPACE: begin
            level_d = 1'b0;
            if (ends) begin
              if (bit_q == BitLast) begin
                phase_d = PH_IDLE;
                bit_d   = '0;
                done    = 1'b1;
              end else begin
                phase_d = PH_BIT_BURST;
                bit_d   = bit_q + 1'b1;
                shift_d = shift_q << 1;
              end
            end
          end
          default: begin
            phase_d = PH_IDLE;
            tick_d  = tick_q;
          end
        endcase
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (pop_o) begin
      out_valid_d      = 1'b1;
      out_d.ir_level   = level_d;
      out_d.busy_res   = (phase_d != PH_IDLE);
      out_d.frame_done = done;
      out_d.rejected   = rej;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      tick_q      <= '0;
      bit_q       <= '0;
      shift_q     <= '0;
      level_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      tick_q      <= tick_d;
      bit_q       <= bit_d;
      shift_q     <= shift_d;
      level_q     <= level_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_len_q   <= ir_pwfs_pkg::HeaderTicksRst;
      zero_len_q  <= ir_pwfs_pkg::ZeroTicksRst;
      one_len_q   <= ir_pwfs_pkg::OneTicksRst;
      space_len_q <= ir_pwfs_pkg::SpaceTicksRst;
    end else if (cfg_we_i) begin
      unique case (ir_pwfs_pkg::cfg_reg_e'(cfg_idx_i))
        ir_pwfs_pkg::REG_HEADER: hdr_len_q   <= cfg_wdata_i;
        ir_pwfs_pkg::REG_ZERO:   zero_len_q  <= cfg_wdata_i;
        ir_pwfs_pkg::REG_ONE:    one_len_q   <= cfg_wdata_i;
        ir_pwfs_pkg::REG_SPACE:  space_len_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  `IRPW_ASSERT_NOW(a_idle_count_clear, clk_i, rst_ni,
    phase_q == PH_IDLE, tick_q == '0 && bit_q == '0)
  `IRPW_ASSERT_NOW(a_done_not_busy, clk_i, rst_ni,
    out_valid_q && out_q.frame_done, !out_q.busy_res && !out_q.rejected)
  `IRPW_ASSERT_NEXT(a_busy_send_rejected, clk_i, rst_ni,
    pop_o && pop_data_i.cmd == ir_pwfs_pkg::CMD_SEND && phase_q != PH_IDLE,
    out_valid_q && out_q.rejected && phase_q == $past(phase_q))

endmodule

`default_nettype wire

/* hdl/ir_pulse_width_frame_sender.sv */
`default_nettype none

// IR pulse-width frame sender. Each transfer on the input is a carrier half-period
// tick or a send request; each produces exactly one result transfer holding the
// emitter level, busy, frame-done and rejected flags. Items enter a classifying
// front register, wait in a two-entry queue and are executed by the frame state
// machine, which drives a registered output stage. One item is taken every cycle
// when the output side is ready; an item's result passes the front register, the
// queue and the output register before it becomes valid. The user must write
// burst and space lengths through the config port only while idle; the block
// itself does not enforce this. A length of zero behaves as one tick.

module ir_pulse_width_frame_sender #(
  parameter int unsigned CODE_BITS = ir_pwfs_pkg::CodeBitsDef
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  output logic                                 in_ready_o,
  input  wire ir_pwfs_pkg::in_item_t           in_data_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  output ir_pwfs_pkg::out_item_t               out_data_o,
  input  wire logic                            cfg_we_i,
  input  wire logic [ir_pwfs_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [ir_pwfs_pkg::TickW-1:0]   cfg_wdata_i
);

  logic                push, push_ready, pop_valid, pop;
  ir_pwfs_pkg::entry_t push_data, pop_data;

  ir_pwfs_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_data_i    (in_data_i),
    .push_o       (push),
    .push_ready_i (push_ready),
    .push_data_o  (push_data)
  );

  ir_pwfs_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_i        (pop),
    .pop_data_o   (pop_data)
  );

  ir_pwfs_back #(
    .CODE_BITS (CODE_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .pop_valid_i (pop_valid),
    .pop_o       (pop),
    .pop_data_i  (pop_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire
